@@ sv/psh_pkg.sv @@
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants for the path string hash block.
// ----------------------------------------------------------------------------
package psh_pkg;

   // default limit on full words mixed per path
   localparam int MAX_WORDS_DEF = 64;

   // words mixed after the path itself
   localparam logic [31:0] FINAL_WORD_0 = 32'h9BE7_4448;
   localparam logic [31:0] FINAL_WORD_1 = 32'h66F4_2C48;

   // reset values of the mixing state
   localparam logic [31:0] ROT_INIT  = 32'hF4FA_8928;
   localparam logic [31:0] MIXA_INIT = 32'h7758_B42B;
   localparam logic [31:0] MIXB_INIT = 32'h37A8_470E;

   // round constants
   localparam logic [31:0] ROUND_KEY  = 32'h267B_0B11;
   localparam logic [31:0] B_OR_MASK  = 32'h0204_0801;
   localparam logic [31:0] B_AND_MASK = 32'hBFEF_7FDF;
   localparam logic [31:0] A_OR_MASK  = 32'h0080_4021;
   localparam logic [31:0] A_AND_MASK = 32'h7DFE_FBFF;

   // word queue between front and mixer; depth is a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one queue entry: a full word, or the end of a path with its partial word
   typedef struct packed {
      logic        is_end;
      logic        has_partial;
      logic [31:0] word;
   } psh_entry_type;

endpackage

@@ sv/psh_req_if.sv @@
// ----------------------------------------------------------------------------
// psh_req_if
// Request channel: one path character or an end marker.
// ----------------------------------------------------------------------------
interface psh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_req;

   modport source (output valid, output ch, output end_req, input ready);
   modport sink   (input valid, input ch, input end_req, output ready);
endinterface

@@ sv/psh_rsp_if.sv @@
// ----------------------------------------------------------------------------
// psh_rsp_if
// Response channel: one 32-bit path hash.
// ----------------------------------------------------------------------------
interface psh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash;

   modport source (output valid, output hash, input ready);
   modport sink   (input valid, input hash, output ready);
endinterface

@@ sv/path_string_hash.sv @@
// ----------------------------------------------------------------------------
// path_string_hash
// 32-bit hash of a path fed one character per request.
// ----------------------------------------------------------------------------
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    ch[7:0], end_req
//   rsp_chan   out  valid/ready    hash[31:0] (one per end_req request)
//
// Front end takes one request per cycle while the word queue has room; it
// lower-cases A-Z, maps '/' to '\', packs bytes little-endian into words.
// Mixer runs one round through the PREP, MULB, MULA and FOLD states on a
// single shared 32x32 multiplier, so sustained input is one character per
// cycle while the response does not stall; an end request adds up to 3
// rounds plus the S_EMIT state that loads the response register.
// Characters past MAX_WORDS full words are dropped. Synchronous reset
// restores all hash state; a stalled response holds the mixer, the queue
// then fills and the request side stalls.
// ----------------------------------------------------------------------------
module path_string_hash #(
   parameter int MAX_WORDS = psh_pkg::MAX_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   psh_req_if.sink     req_chan,
   psh_rsp_if.source   rsp_chan
);
   import psh_pkg::*;

   logic          push_valid;
   logic          push_ready;
   psh_entry_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   psh_entry_type pop_data;

   // classify and pack
   psh_front #(
      .MAX_WORDS (MAX_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples front from mixer stalls
   psh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // rounds, finalization, response register
   psh_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ sv/psh_front.sv @@
// ----------------------------------------------------------------------------
// psh_front
// Normalizes characters, packs them into words and queues words and ends.
// ----------------------------------------------------------------------------
module psh_front #(
   parameter int MAX_WORDS = psh_pkg::MAX_WORDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   psh_req_if.sink                req_chan,
   output logic                   push_valid,
   input  logic                   push_ready,
   output psh_pkg::psh_entry_type push_data
);
   import psh_pkg::*;

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   logic [23:0]      buf_ff, buf_in;
   logic [1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             take_char;
   logic [7:0]       norm_ch;

   function automatic logic [7:0] normalize(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end else if (c == 8'h2F) begin
         r = 8'h5C;
      end
      return r;
   endfunction

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign norm_ch        = normalize(req_chan.ch);
   assign take_char      = accept && !req_chan.end_req && (req_chan.ch != 8'h00)
                           && (count_ff < CNT_W'(MAX_WORDS));

   always_comb begin
      buf_in     = buf_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      push_data  = '{is_end: 1'b0, has_partial: 1'b0, word: {norm_ch, buf_ff}};
      if (accept && req_chan.end_req) begin
         push_valid = 1'b1;
         push_data  = '{is_end: 1'b1, has_partial: (pos_ff != 2'd0),
                        word: {8'h00, buf_ff}};
         buf_in     = '0;
         pos_in     = '0;
         count_in   = '0;
      end else if (take_char) begin
         if (pos_ff == 2'd3) begin
            push_valid = 1'b1;
            buf_in     = '0;
            pos_in     = '0;
            count_in   = count_ff + CNT_W'(1);
         end else begin
            case (pos_ff)
               2'd0:    buf_in[7:0]   = norm_ch;
               2'd1:    buf_in[15:8]  = norm_ch;
               default: buf_in[23:16] = norm_ch;
            endcase
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         buf_ff   <= buf_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ sv/psh_queue.sv @@
// ----------------------------------------------------------------------------
// psh_queue
// Small FIFO of words between the front end and the mixer.
// ----------------------------------------------------------------------------
module psh_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  psh_pkg::psh_entry_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output psh_pkg::psh_entry_type pop_data
);
   import psh_pkg::*;

   psh_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/psh_mix.sv @@
// ----------------------------------------------------------------------------
// psh_mix
// Mixing engine: rounds on one shared 32x32 multiplier,
// end-of-path sequencing and the response register.
// ----------------------------------------------------------------------------
module psh_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  psh_pkg::psh_entry_type pop_data,
   psh_rsp_if.source              rsp_chan
);
   import psh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_MULB, S_MULA, S_FOLD, S_EMIT
   } state_type;

   // what follows the round in flight
   typedef enum logic [1:0] {
      NX_NONE, NX_F0, NX_F1, NX_EMIT
   } next_type;

   state_type   state_ff, state_in;
   next_type    next_ff, next_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] rot_ff, rot_in;
   logic [31:0] mix_a_ff, mix_a_in;
   logic [31:0] mix_b_ff, mix_b_in;
   logic [31:0] a_x_ff, a_x_in;
   logic [31:0] b_x_ff, b_x_in;
   logic [31:0] opb_ff, opb_in;
   logic [31:0] opa_ff, opa_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] newb_ff, newb_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;

   logic [31:0] rot_next, key, ax, bx;
   logic [31:0] mul_x, mul_y;
   logic [63:0] product;
   logic [31:0] hi, lo, lo_b, lo_a, dbl, fold_b, fold_a;
   logic [32:0] sum_b, sum_a;
   logic        load;

   // round setup
   assign rot_next = {rot_ff[30:0], rot_ff[31]};
   assign key      = ROUND_KEY ^ rot_next;
   assign ax       = mix_a_ff ^ word_ff;
   assign bx       = mix_b_ff ^ word_ff;

   // shared multiplier
   assign mul_x   = (state_ff == S_MULB) ? opb_ff : a_x_ff;
   assign mul_y   = (state_ff == S_MULB) ? b_x_ff : opa_ff;
   assign product = {32'h0, mul_x} * {32'h0, mul_y};

   // end-around folds of the registered product
   assign hi     = prod_ff[63:32];
   assign lo     = prod_ff[31:0];
   assign lo_b   = lo + {31'h0, (hi != 32'h0)};
   assign sum_b  = {1'b0, lo_b} + {1'b0, hi};
   assign fold_b = sum_b[31:0] + {31'h0, sum_b[32]};
   assign dbl    = {hi[30:0], 1'b0};
   assign lo_a   = lo + {31'h0, hi[31]};
   assign sum_a  = {1'b0, lo_a} + {1'b0, dbl};
   assign fold_a = sum_a[31:0] + {30'h0, sum_a[32], 1'b0};

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hash  = rsp_hash_ff;

   always_comb begin
      state_in     = state_ff;
      next_in      = next_ff;
      word_in      = word_ff;
      rot_in       = rot_ff;
      mix_a_in     = mix_a_ff;
      mix_b_in     = mix_b_ff;
      a_x_in       = a_x_ff;
      b_x_in       = b_x_ff;
      opb_in       = opb_ff;
      opa_in       = opa_ff;
      prod_in      = prod_ff;
      newb_in      = newb_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      load         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            load = pop_valid;
         end
         S_PREP: begin
            rot_in   = rot_next;
            a_x_in   = ax;
            b_x_in   = bx;
            opb_in   = ((key + ax) | B_OR_MASK) & B_AND_MASK;
            opa_in   = ((key + bx) | A_OR_MASK) & A_AND_MASK;
            state_in = S_MULB;
         end
         S_MULB: begin
            prod_in  = product;
            state_in = S_MULA;
         end
         S_MULA: begin
            newb_in  = fold_b;
            prod_in  = product;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            mix_a_in = fold_a;
            mix_b_in = newb_ff;
            case (next_ff)
               NX_F0: begin
                  word_in  = FINAL_WORD_0;
                  next_in  = NX_F1;
                  state_in = S_PREP;
               end
               NX_F1: begin
                  word_in  = FINAL_WORD_1;
                  next_in  = NX_EMIT;
                  state_in = S_PREP;
               end
               NX_EMIT: begin
                  state_in = S_EMIT;
               end
               default: begin
                  // chain straight into the next queued word
                  load     = pop_valid;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = mix_a_ff ^ mix_b_ff;
               rot_in       = ROT_INIT;
               mix_a_in     = MIXA_INIT;
               mix_b_in     = MIXB_INIT;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         state_in = S_PREP;
         if (!pop_data.is_end) begin
            word_in = pop_data.word;
            next_in = NX_NONE;
         end else if (pop_data.has_partial) begin
            word_in = pop_data.word;
            next_in = NX_F0;
         end else begin
            word_in = FINAL_WORD_0;
            next_in = NX_F1;
         end
      end
   end

   assign pop_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_ff      <= NX_NONE;
         rot_ff       <= ROT_INIT;
         mix_a_ff     <= MIXA_INIT;
         mix_b_ff     <= MIXB_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         rot_ff       <= rot_in;
         mix_a_ff     <= mix_a_in;
         mix_b_ff     <= mix_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      a_x_ff      <= a_x_in;
      b_x_ff      <= b_x_in;
      opb_ff      <= opb_in;
      opa_ff      <= opa_in;
      prod_ff     <= prod_in;
      newb_ff     <= newb_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule
